/* design/queue_with_delete_by_id_unit_assert.svh */
`ifndef QUEUE_WITH_DELETE_BY_ID_UNIT_ASSERT_SVH
`define QUEUE_WITH_DELETE_BY_ID_UNIT_ASSERT_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define QWD_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define QWD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/qwd_pkg.sv */
package qwd_pkg;

  localparam int DepthDefault = 256;

  localparam int FuncW   = 2;
  localparam int IdW     = 32;
  localparam int StatusW = 2;
  localparam int CountW  = 9;

  // out_ident and count, padded to whole bytes
  localparam int OutDataW = ((IdW + CountW + 7) / 8) * 8;

  typedef enum logic [FuncW-1:0] {
    FUNC_ENQ    = 2'd0,
    FUNC_REMOVE = 2'd1,
    FUNC_DEQ    = 2'd2,
    FUNC_NOP    = 2'd3
  } func_e;

  typedef enum logic [StatusW-1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_NOT_FOUND = 2'd2,
    STAT_EMPTY     = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_SHIFT
  } cell_op_e;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  // Broadcast from the controller to every cell
  typedef struct packed {
    logic           cmp;
    cell_op_e       op;
    logic [IdW-1:0] key;
  } cell_ctrl_t;

endpackage

/* design/queue_with_delete_by_id_unit.sv */
// Channel   Dir  tdata                                     tuser
// s_axis    in   [31:0] ident                              [1:0] func
// m_axis    out  [31:0] out_ident, [40:32] count, 0 pad    [1:0] status
//
// An operation is accepted in S_IDLE and run in S_EXEC. The accept edge compares
// the key in every cell at once; S_EXEC resolves the first match through a prefix
// OR and shifts or loads the cells. A held result stalls S_EXEC only; the next
// operation is accepted while the result waits. After reset the queue is empty
// and ready at once. All operations share the one cell row.
module queue_with_delete_by_id_unit #(
  parameter int DEPTH = qwd_pkg::DepthDefault
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [qwd_pkg::IdW-1:0]         s_axis_tdata,   // [31:0] ident
  input  logic [qwd_pkg::FuncW-1:0]       s_axis_tuser,   // [1:0] func
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [qwd_pkg::OutDataW-1:0]    m_axis_tdata,   // [31:0] out_ident, [40:32] count
  output logic [qwd_pkg::StatusW-1:0]     m_axis_tuser    // [1:0] status
);
  import qwd_pkg::*;

  localparam int CntW = $clog2(DEPTH + 1);

  state_e          state_q, state_d;
  func_e           func_q;
  logic [IdW-1:0]  key_q;
  logic [CntW-1:0] count_q, count_d;

  logic                m_valid_q, m_valid_d;
  logic [IdW-1:0]      m_ident_q, m_ident_d;
  logic [CountW-1:0]   m_count_q, m_count_d;
  status_e             m_status_q, m_status_d;

  cell_ctrl_t      cell_ctrl;
  logic            deq_sel;
  logic            accept;
  logic            slot_free;
  logic            found;

  logic [DEPTH-1:0] valid_vec;
  logic [DEPTH-1:0] match_vec;
  logic [DEPTH-1:0] prefix_vec;
  logic [DEPTH-1:0] shift_vec;
  logic [IdW-1:0]   ident_arr [DEPTH];
  logic [CntW+CountW-1:0] count_ext;

  assign accept    = s_axis_tvalid && s_axis_tready;
  assign slot_free = !m_valid_q || m_axis_tready;
  assign found     = prefix_vec[DEPTH-1];
  assign shift_vec = deq_sel ? {DEPTH{1'b1}} : prefix_vec;
  assign count_ext = {{CountW{1'b0}}, count_d};

  // Cell row
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic           prev_valid;
    logic           next_valid;
    logic [IdW-1:0] next_ident;

    if (i == 0) begin : g_head
      assign prev_valid = 1'b1;
    end else begin : g_body
      assign prev_valid = valid_vec[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign next_valid = 1'b0;
      assign next_ident = '0;
    end else begin : g_inner
      assign next_valid = valid_vec[i+1];
      assign next_ident = ident_arr[i+1];
    end

    qwd_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (cell_ctrl),
      .shift_i      (shift_vec[i]),
      .prev_valid_i (prev_valid),
      .next_valid_i (next_valid),
      .next_ident_i (next_ident),
      .valid_o      (valid_vec[i]),
      .ident_o      (ident_arr[i]),
      .match_o      (match_vec[i])
    );
  end

  qwd_prefix_or #(
    .N (DEPTH)
  ) u_prefix (
    .vec_i (match_vec),
    .pre_o (prefix_vec)
  );

  always_comb begin
    state_d       = state_q;
    count_d       = count_q;
    m_valid_d     = m_valid_q && !m_axis_tready;
    m_ident_d     = m_ident_q;
    m_count_d     = m_count_q;
    m_status_d    = m_status_q;
    deq_sel       = 1'b0;
    s_axis_tready = 1'b0;
    cell_ctrl.cmp = 1'b0;
    cell_ctrl.op  = CELL_HOLD;
    cell_ctrl.key = key_q;

    unique case (state_q)
      S_IDLE: begin
        s_axis_tready = 1'b1;
        cell_ctrl.key = s_axis_tdata;
        cell_ctrl.cmp = s_axis_tvalid;
        if (s_axis_tvalid) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (slot_free) begin
          m_ident_d  = '0;
          m_status_d = STAT_OK;
          unique case (func_q)
            FUNC_ENQ: begin
              if (count_q == CntW'(DEPTH)) begin
                m_status_d = STAT_FULL;
              end else begin
                cell_ctrl.op = CELL_LOAD;
                count_d      = count_q + 1'b1;
              end
            end
            FUNC_REMOVE: begin
              if (found) begin
                cell_ctrl.op = CELL_SHIFT;
                count_d      = count_q - 1'b1;
              end else begin
                m_status_d = STAT_NOT_FOUND;
              end
            end
            FUNC_DEQ: begin
              if (count_q == '0) begin
                m_status_d = STAT_EMPTY;
              end else begin
                deq_sel      = 1'b1;
                cell_ctrl.op = CELL_SHIFT;
                m_ident_d    = ident_arr[0];
                count_d      = count_q - 1'b1;
              end
            end
            FUNC_NOP: begin
            end
            default: begin
            end
          endcase
          m_count_d = count_ext[CountW-1:0];
          m_valid_d = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      m_valid_q <= m_valid_d;
    end
  end

  // Payload: no reset
  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q <= func_e'(s_axis_tuser);
      key_q  <= s_axis_tdata;
    end
    m_ident_q  <= m_ident_d;
    m_count_q  <= m_count_d;
    m_status_q <= m_status_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_status_q;
  assign m_axis_tdata  = {{(OutDataW - IdW - CountW){1'b0}}, m_count_q, m_ident_q};

`include "queue_with_delete_by_id_unit_assert.svh"

  `QWD_ASSERT_IMPL(a_count_bound, 1'b1, count_q <= CntW'(DEPTH), "count above depth")
  `QWD_ASSERT_IMPL(a_valid_count, 1'b1, $countones(valid_vec) == count_q, "valid bits disagree with count")
  `QWD_ASSERT_IMPL(a_compact, 1'b1, (valid_vec[DEPTH-1:1] & ~valid_vec[DEPTH-2:0]) == '0, "hole in cell row")
  `QWD_ASSERT_NEXT(a_deq_count, (state_q == S_EXEC) && slot_free && (func_q == FUNC_DEQ) && (count_q != '0), count_q == $past(count_q) - 1'b1, "dequeue did not lower count")
  `QWD_ASSERT_IMPL(a_result_src, $rose(m_valid_q), $past(state_q == S_EXEC), "result without execute cycle")

endmodule

/* design/qwd_cell.sv */
module qwd_cell (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  qwd_pkg::cell_ctrl_t        ctrl_i,
  input  logic                       shift_i,
  input  logic                       prev_valid_i,
  input  logic                       next_valid_i,
  input  logic [qwd_pkg::IdW-1:0]    next_ident_i,
  output logic                       valid_o,
  output logic [qwd_pkg::IdW-1:0]    ident_o,
  output logic                       match_o
);
  import qwd_pkg::*;

  logic           valid_q, valid_d;
  logic [IdW-1:0] ident_q, ident_d;
  logic           match_q, match_d;
  logic           tail;

  // First empty cell behind a full one is the tail slot
  assign tail = !valid_q && prev_valid_i;

  always_comb begin
    valid_d = valid_q;
    ident_d = ident_q;
    unique case (ctrl_i.op)
      CELL_HOLD: begin
      end
      CELL_LOAD: begin
        if (tail) begin
          valid_d = 1'b1;
          ident_d = ctrl_i.key;
        end
      end
      CELL_SHIFT: begin
        // take the neighbor toward the tail, closing the gap
        if (shift_i) begin
          valid_d = next_valid_i;
          ident_d = next_ident_i;
        end
      end
      default: begin
      end
    endcase
    match_d = ctrl_i.cmp ? (valid_q && (ident_q == ctrl_i.key)) : match_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      match_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      match_q <= match_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ident_q <= ident_d;
  end

  assign valid_o = valid_q;
  assign ident_o = ident_q;
  assign match_o = match_q;

endmodule

/* design/qwd_prefix_or.sv */
module qwd_prefix_or #(
  parameter int N = qwd_pkg::DepthDefault
) (
  input  logic [N-1:0] vec_i,
  output logic [N-1:0] pre_o
);
  import qwd_pkg::*;

  localparam int Levels = (N > 1) ? $clog2(N) : 1;

  logic [N-1:0] lvl [Levels+1];

  assign lvl[0] = vec_i;

  // Parallel prefix: bit i becomes the OR of bits 0 to i
  for (genvar s = 0; s < Levels; s++) begin : g_lvl
    for (genvar i = 0; i < N; i++) begin : g_bit
      if (i >= (1 << s)) begin : g_or
        assign lvl[s+1][i] = lvl[s][i] | lvl[s][i - (1 << s)];
      end else begin : g_pass
        assign lvl[s+1][i] = lvl[s][i];
      end
    end
  end

  assign pre_o = lvl[Levels];

endmodule

/* tb/sv/tb_queue_with_delete_by_id_unit.sv */
`timescale 1ns / 100ps

module tb_queue_with_delete_by_id_unit;
  import qwd_pkg::*;

  localparam int Depth     = DepthDefault;
  localparam int IdleLimit = 4000;
  localparam int MaxPrints = 40;

  typedef struct packed {
    logic [IdW-1:0]    ident;
    status_e           status;
    logic [CountW-1:0] count;
  } queue_result_t;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [IdW-1:0]      s_axis_tdata;
  logic [FuncW-1:0]    s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;
  logic [StatusW-1:0]  m_axis_tuser;

  // Shadow of the queue contents, head at index 0
  logic [IdW-1:0] held_ids[$];
  queue_result_t  expected_results[$];

  int sender_idle_pct = 0;
  int sink_stall_pct  = 0;
  int holdoff_req     = 0;
  int mismatch_count  = 0;
  int items_sent      = 0;
  int results_seen    = 0;
  int full_hits       = 0;
  int empty_hits      = 0;
  int missing_hits    = 0;
  int max_fill        = 0;

  queue_with_delete_by_id_unit #(
    .DEPTH(Depth)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    if (mismatch_count < MaxPrints) begin
      $display("ERROR result %0d: %s got 0x%0h, want 0x%0h", results_seen, what, got, want);
    end
    mismatch_count++;
  endtask

  // Update the shadow queue with one accepted operation and queue its result
  task automatic apply_queue_op(func_e op, logic [IdW-1:0] id);
    queue_result_t r;
    int            hit;
    r.ident  = '0;
    r.status = STAT_OK;
    hit      = -1;
    case (op)
      FUNC_ENQ: begin
        if (held_ids.size() >= Depth) begin
          r.status = STAT_FULL;
          full_hits++;
        end else begin
          held_ids.push_back(id);
        end
      end
      FUNC_REMOVE: begin
        for (int k = 0; k < held_ids.size(); k++) begin
          if (hit < 0 && held_ids[k] == id) hit = k;
        end
        if (hit >= 0) begin
          held_ids.delete(hit);
        end else begin
          r.status = STAT_NOT_FOUND;
          missing_hits++;
        end
      end
      FUNC_DEQ: begin
        if (held_ids.size() == 0) begin
          r.status = STAT_EMPTY;
          empty_hits++;
        end else begin
          r.ident = held_ids.pop_front();
        end
      end
      default: ;
    endcase
    r.count = CountW'(held_ids.size());
    if (held_ids.size() > max_fill) max_fill = held_ids.size();
    expected_results.push_back(r);
  endtask

  // Offer one operation; valid stays high on return so back-to-back items need no drop
  task automatic send_op(func_e op, logic [IdW-1:0] id);
    while ($urandom_range(99) < sender_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= $urandom;
      s_axis_tuser  <= FuncW'($urandom_range(3));
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= id;
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
    apply_queue_op(op, id);
  endtask

  task automatic wait_drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [IdW-1:0] pick_present_id();
    if (held_ids.size() == 0) return $urandom;
    return held_ids[$urandom_range(held_ids.size() - 1)];
  endfunction

  task automatic send_random_op(int enq_pct);
    func_e          op;
    logic [IdW-1:0] id;
    if ($urandom_range(99) < 4) begin
      op = FUNC_NOP;
    end else if ($urandom_range(99) < enq_pct) begin
      op = FUNC_ENQ;
    end else if ($urandom_range(1) == 0) begin
      op = FUNC_REMOVE;
    end else begin
      op = FUNC_DEQ;
    end
    // small pool of keys so duplicates and repeated removes show up
    if (op == FUNC_REMOVE && $urandom_range(99) < 80) id = pick_present_id();
    else if (op != FUNC_DEQ && $urandom_range(99) < 35) id = IdW'($urandom_range(7));
    else id = $urandom;
    send_op(op, id);
  endtask

  task automatic test_directed();
    sender_idle_pct = 0;
    sink_stall_pct  = 0;
    send_op(FUNC_DEQ, 32'hFFFF_FFFF);
    send_op(FUNC_REMOVE, 32'h0000_0000);
    send_op(FUNC_ENQ, 32'h0000_0000);
    send_op(FUNC_ENQ, 32'hFFFF_FFFF);
    send_op(FUNC_ENQ, 32'h5A5A_A5A5);
    send_op(FUNC_ENQ, 32'h0000_0000);
    send_op(FUNC_ENQ, 32'h8000_0001);
    send_op(FUNC_NOP, 32'hFFFF_FFFF);
    send_op(FUNC_REMOVE, 32'h1234_5678);
    send_op(FUNC_REMOVE, 32'hFFFF_FFFF);
    send_op(FUNC_REMOVE, 32'h0000_0000);
    send_op(FUNC_REMOVE, 32'h8000_0001);
    send_op(FUNC_DEQ, 32'h0000_0000);
    send_op(FUNC_DEQ, 32'hFFFF_FFFF);
    send_op(FUNC_DEQ, 32'h0000_0000);
    send_op(FUNC_REMOVE, 32'h0000_0000);
    send_op(FUNC_ENQ, 32'hA5A5_5A5A);
    send_op(FUNC_ENQ, 32'hA5A5_5A5A);
    send_op(FUNC_REMOVE, 32'hA5A5_5A5A);
    send_op(FUNC_NOP, 32'h0000_0000);
    send_op(FUNC_DEQ, 32'h0000_0000);
    send_op(FUNC_DEQ, 32'h0000_0000);
    wait_drain();
  endtask

  task automatic test_fill_and_drain();
    sender_idle_pct = 0;
    sink_stall_pct  = 20;
    while (held_ids.size() < Depth) send_op(FUNC_ENQ, $urandom);
    send_op(FUNC_ENQ, 32'hFFFF_FFFF);
    send_op(FUNC_ENQ, 32'h0000_0000);
    send_op(FUNC_NOP, $urandom);
    send_op(FUNC_REMOVE, ~held_ids[0] ^ held_ids[1]);
    send_op(FUNC_REMOVE, held_ids[Depth-1]);
    send_op(FUNC_REMOVE, held_ids[0]);
    send_op(FUNC_REMOVE, held_ids[Depth/2]);
    while (held_ids.size() < Depth) send_op(FUNC_ENQ, $urandom);
    send_op(FUNC_ENQ, $urandom);
    while (held_ids.size() > 0) send_op(FUNC_DEQ, $urandom);
    send_op(FUNC_DEQ, $urandom);
    send_op(FUNC_REMOVE, $urandom);
    wait_drain();
  endtask

  task automatic test_random_mix();
    int idle_set[4]  = '{0, 57, 0, 37};
    int stall_set[4] = '{0, 0, 57, 37};
    int enq_set[7]   = '{85, 20, 60, 95, 10, 50, 70};
    for (int phase = 0; phase < 4; phase++) begin
      sender_idle_pct = idle_set[phase];
      sink_stall_pct  = stall_set[phase];
      for (int chunk = 0; chunk < 7; chunk++) begin
        for (int n = 0; n < 50; n++) send_random_op(enq_set[(chunk + phase) % 7]);
      end
      wait_drain();
    end
  endtask

  task automatic test_backpressure();
    sender_idle_pct = 0;
    sink_stall_pct  = 0;
    holdoff_req     = 400;
    for (int n = 0; n < 120; n++) send_random_op(60);
    wait_drain();
  endtask

  // Result sink: random stalls plus an optional long hold-off
  initial begin
    int left;
    left          = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (holdoff_req > 0) begin
        left        = holdoff_req;
        holdoff_req = 0;
      end
      if (left > 0) begin
        left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    queue_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected transaction", 64'(m_axis_tdata), '0);
      end else begin
        want = expected_results.pop_front();
        if (m_axis_tdata[IdW-1:0] !== want.ident)
          report_mismatch("out_ident", 64'(m_axis_tdata[IdW-1:0]), 64'(want.ident));
        if (m_axis_tdata[IdW +: CountW] !== want.count)
          report_mismatch("count", 64'(m_axis_tdata[IdW +: CountW]), 64'(want.count));
        if (m_axis_tuser !== want.status)
          report_mismatch("status", 64'(m_axis_tuser), 64'(want.status));
      end
      results_seen++;
    end
  end

  // Abort when neither side moves a transaction for too long
  always @(posedge clk_i) begin
    int quiet;
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= IdleLimit) begin
        $display("Timeout after %0d idle cycles, %0d results pending",
                 quiet, expected_results.size());
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = FUNC_NOP;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_fill_and_drain();
    test_random_mix();
    test_backpressure();
    repeat (20) @(posedge clk_i);
    $display("Ran %0d operations, checked %0d results, peak fill %0d of %0d",
             items_sent, results_seen, max_fill, Depth);
    $display("Status hits: full %0d, not found %0d, empty %0d",
             full_hits, missing_hits, empty_hits);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
